### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the scoped binding stack RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sbs_pkg.sv
// ---------------------------------------------------------------------------
// sbs_pkg
// Types, field widths and codes shared by the scoped binding stack.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbs_pkg;

  // Default configuration
  localparam int STACK_DEPTH_DEF = 1024;
  localparam int KEY_BITS_DEF    = 14;

  // Payload field widths
  localparam int CMD_W    = 2;
  localparam int ATOM_W   = 14;
  localparam int FRAME_W  = 16;
  localparam int IDX_W    = 10;
  localparam int OFS_W    = 10;
  localparam int ADDR_W   = 17;
  localparam int STATUS_W = 2;
  localparam int LCNT_W   = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_FIND  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOFRAME  = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;      // latch the incoming item
    logic exec_push;    // perform add or open frame and load its result
    logic walk_start;   // read the top entry
    logic walk_step;    // move one entry down and read it
    logic finish_walk;  // load the result of the walk (hit or bottom reached)
    logic finish_none;  // load the miss result of an empty stack
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_push;   // latched command is add or open frame
    logic top_zero;  // stack is empty
    logic hit;       // entry under the walk pointer matches
    logic ptr_zero;  // walk pointer is at the bottom entry
    logic out_free;  // result register can take a new result
  } sts_t;

endpackage

### hw/rtl/sbs_if.sv
// ---------------------------------------------------------------------------
// sbs_if
// Valid/ready channels for commands in and results out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sbs_in_if;
  import sbs_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]   command;
  logic [ATOM_W-1:0]  atom_key;
  logic [FRAME_W-1:0] frame_base;

  modport source (output valid, command, atom_key, frame_base, input ready);
  modport sink   (input valid, command, atom_key, frame_base, output ready);
endinterface

interface sbs_out_if;
  import sbs_pkg::*;

  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    entry_index;
  logic                found;
  logic [FRAME_W-1:0]  bound_frame;
  logic [OFS_W-1:0]    local_offset;
  logic [ADDR_W-1:0]   var_address;
  logic [STATUS_W-1:0] status;

  modport source (output valid, entry_index, found, bound_frame, local_offset,
                  var_address, status, input ready);
  modport sink   (input valid, entry_index, found, bound_frame, local_offset,
                  var_address, status, output ready);
endinterface

### hw/rtl/sbs_ram.sv
// ---------------------------------------------------------------------------
// sbs_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/sbs_ctrl.sv
// ---------------------------------------------------------------------------
// sbs_ctrl
// Command sequencer: accepts an item, runs push or top-down walk, and
// hands the result to the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sbs_pkg::sts_t sts,
  output sbs_pkg::ctl_t ctl
);
  import sbs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_WALK = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_push) begin
          if (sts.out_free) begin
            ctl.exec_push = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (sts.top_zero) begin
          if (sts.out_free) begin
            ctl.finish_none = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else begin
          ctl.walk_start = 1'b1;
          state_nxt      = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.hit || sts.ptr_zero) begin
          if (sts.out_free) begin
            ctl.finish_walk = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else begin
          ctl.walk_step = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Results load only into a free output register
  `SBS_ASSERT_IMP(a_load_free, clk, rst_n, ctl.exec_push || ctl.finish_walk || ctl.finish_none, sts.out_free, "result loaded while output register busy")
  // A walk never runs on an empty stack
  `SBS_ASSERT_IMP(a_walk_nonempty, clk, rst_n, state_r == S_WALK, !sts.top_zero, "walk on empty stack")
  // A captured item reaches the execute state in the next cycle
  `SBS_ASSERT_NXT(a_capture_exec, clk, rst_n, ctl.capture, state_r == S_EXEC, "captured item not executed")

endmodule

### hw/rtl/sbs_dp.sv
// ---------------------------------------------------------------------------
// sbs_dp
// Datapath: entry RAM, stack top, frame and local count, walk pointer and
// the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbs_dp #(
  parameter int STACK_DEPTH = sbs_pkg::STACK_DEPTH_DEF,
  parameter int KEY_BITS    = sbs_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sbs_pkg::ctl_t                 ctl,
  output sbs_pkg::sts_t                 sts,
  input  logic [sbs_pkg::CMD_W-1:0]     in_command,
  input  logic [sbs_pkg::ATOM_W-1:0]    in_atom_key,
  input  logic [sbs_pkg::FRAME_W-1:0]   in_frame_base,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sbs_pkg::IDX_W-1:0]     out_entry_index,
  output logic                          out_found,
  output logic [sbs_pkg::FRAME_W-1:0]   out_bound_frame,
  output logic [sbs_pkg::OFS_W-1:0]     out_local_offset,
  output logic [sbs_pkg::ADDR_W-1:0]    out_var_address,
  output logic [sbs_pkg::STATUS_W-1:0]  out_status
);
  import sbs_pkg::*;

  localparam int AW     = $clog2(STACK_DEPTH);
  localparam int TW     = $clog2(STACK_DEPTH + 1);
  localparam int WORD_W = 1 + KEY_BITS + FRAME_W + LCNT_W;

  // Architectural state
  logic [TW-1:0]      top_r, top_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [LCNT_W-1:0]  lcnt_r, lcnt_nxt;

  // Latched item and walk pointer
  cmd_t               cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic [FRAME_W-1:0] fbase_r;
  logic [AW-1:0]      ptr_r, ptr_nxt;
  logic [KEY_BITS-1:0] key_in;

  // Result register
  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    o_index_r;
  logic                o_found_r;
  logic [FRAME_W-1:0]  o_frame_r;
  logic [OFS_W-1:0]    o_ofs_r;
  logic [ADDR_W-1:0]   o_addr_r;
  status_t             o_status_r;

  logic [IDX_W-1:0]    res_index;
  logic                res_found;
  logic [FRAME_W-1:0]  res_frame;
  logic [OFS_W-1:0]    res_ofs;
  logic [ADDR_W-1:0]   res_addr;
  status_t             res_status;
  logic                res_load;

  // RAM access
  logic              ram_we;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  logic              rd_marker;
  logic [KEY_BITS-1:0] rd_key;
  logic [FRAME_W-1:0] rd_frame;
  logic [LCNT_W-1:0]  rd_lcnt;

  logic [TW-1:0] top_dec;
  logic [AW-1:0] ptr_dec;
  logic          full;
  logic          hit;

  // Cut or zero-extend the incoming key to KEY_BITS
  if (KEY_BITS <= ATOM_W) begin : g_key_cut
    assign key_in = in_atom_key[KEY_BITS-1:0];
  end else begin : g_key_ext
    assign key_in = KEY_BITS'(in_atom_key);
  end

  assign top_dec = top_r - TW'(1);
  assign ptr_dec = ptr_r - AW'(1);
  assign full    = (top_r == TW'(STACK_DEPTH));

  assign {rd_marker, rd_key, rd_frame, rd_lcnt} = ram_rdata;

  // Markers match on close, keyed bindings on find
  assign hit = (cmd_r == CMD_CLOSE) ? rd_marker : (!rd_marker && (rd_key == key_r));

  // Status to the controller
  assign sts.is_push  = (cmd_r == CMD_ADD) || (cmd_r == CMD_OPEN);
  assign sts.top_zero = (top_r == '0);
  assign sts.hit      = hit;
  assign sts.ptr_zero = (ptr_r == '0);
  assign sts.out_free = !out_valid_r || out_ready;

  // Push writes at the top; walk reads one entry per cycle downward
  assign ram_we    = ctl.exec_push && !full;
  assign ram_wdata = (cmd_r == CMD_ADD) ? {1'b0, key_r, frame_r, lcnt_r}
                                        : {1'b1, {KEY_BITS{1'b0}}, frame_r, lcnt_r};

  always_comb begin
    priority if (ctl.walk_start) begin
      ram_raddr = top_dec[AW-1:0];
    end else if (ctl.walk_step) begin
      ram_raddr = ptr_dec;
    end else begin
      ram_raddr = ptr_r;
    end
  end

  sbs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (top_r[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Walk pointer follows the read address
  assign ptr_nxt = ram_raddr;

  // Stack top, frame base and local count
  always_comb begin
    top_nxt   = top_r;
    frame_nxt = frame_r;
    lcnt_nxt  = lcnt_r;
    if (ctl.exec_push && !full) begin
      top_nxt = top_r + TW'(1);
      if (cmd_r == CMD_ADD) begin
        lcnt_nxt = lcnt_r + LCNT_W'(1);
      end else begin
        frame_nxt = fbase_r;
        lcnt_nxt  = '0;
      end
    end else if (ctl.finish_walk && hit && (cmd_r == CMD_CLOSE)) begin
      // Truncate at the marker and restore the outer frame
      top_nxt   = TW'(ptr_r);
      frame_nxt = rd_frame;
      lcnt_nxt  = rd_lcnt;
    end
  end

  // Result of the finishing step
  assign res_load = ctl.exec_push || ctl.finish_walk || ctl.finish_none;

  always_comb begin
    res_index  = '0;
    res_found  = 1'b0;
    res_frame  = '0;
    res_ofs    = '0;
    res_addr   = '0;
    res_status = ST_OK;
    priority if (ctl.exec_push) begin
      if (full) begin
        res_status = ST_FULL;
      end else begin
        res_index = IDX_W'(top_r);
        if (cmd_r == CMD_ADD) begin
          res_ofs = lcnt_r[OFS_W-1:0];
        end
      end
    end else if (ctl.finish_walk && hit) begin
      res_index = IDX_W'(ptr_r);
      if (cmd_r == CMD_FIND) begin
        res_found = 1'b1;
        res_frame = rd_frame;
        res_ofs   = rd_lcnt[OFS_W-1:0];
        res_addr  = ADDR_W'(rd_frame) + ADDR_W'(rd_lcnt[OFS_W-1:0]);
      end
    end else begin
      res_status = (cmd_r == CMD_CLOSE) ? ST_NOFRAME : ST_NOTFOUND;
    end
  end

  // Hold a result until its transfer
  always_comb begin
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
    end
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= '0;
      frame_r     <= '0;
      lcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      top_r       <= top_nxt;
      frame_r     <= frame_nxt;
      lcnt_r      <= lcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (ctl.capture) begin
      cmd_r   <= cmd_t'(in_command);
      key_r   <= key_in;
      fbase_r <= in_frame_base;
    end
    if (res_load) begin
      o_index_r  <= res_index;
      o_found_r  <= res_found;
      o_frame_r  <= res_frame;
      o_ofs_r    <= res_ofs;
      o_addr_r   <= res_addr;
      o_status_r <= res_status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_entry_index  = o_index_r;
  assign out_found        = o_found_r;
  assign out_bound_frame  = o_frame_r;
  assign out_local_offset = o_ofs_r;
  assign out_var_address  = o_addr_r;
  assign out_status       = o_status_r;

  // Stack top stays within the stack
  `SBS_ASSERT_IMP(a_top_bound, clk, rst_n, 1'b1, top_r <= TW'(STACK_DEPTH), "stack top beyond depth")
  // Each walk step moves exactly one entry down
  `SBS_ASSERT_NXT(a_walk_dec, clk, rst_n, ctl.walk_step, ptr_r == AW'($past(ptr_r) - AW'(1)), "walk pointer did not step down")

endmodule

### hw/rtl/scoped_binding_stack_top.sv
// Sequence: an item is taken only while idle; add and open frame load the result register
//   from the execute state; close frame and find first walk the entries from the top down
//   through the single read port, one entry a cycle, to a hit or the bottom (no walk on an
//   empty stack). A new item waits until the last result is loaded into a free register.
// Reset: rst_n clears stack top, frame base, local count and the result valid; the entry
//   RAM is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
// scoped_binding_stack_top
// Lexical binding stack with add, open frame, close frame and find commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scoped_binding_stack_top #(
  parameter int STACK_DEPTH = sbs_pkg::STACK_DEPTH_DEF,
  parameter int KEY_BITS    = sbs_pkg::KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sbs_in_if.sink      in_ch,
  sbs_out_if.source   out_ch
);
  import sbs_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic in_ready;

  assign in_ch.ready = in_ready;

  sbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  sbs_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .in_command       (in_ch.command),
    .in_atom_key      (in_ch.atom_key),
    .in_frame_base    (in_ch.frame_base),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_entry_index  (out_ch.entry_index),
    .out_found        (out_ch.found),
    .out_bound_frame  (out_ch.bound_frame),
    .out_local_offset (out_ch.local_offset),
    .out_var_address  (out_ch.var_address),
    .out_status       (out_ch.status)
  );

endmodule

### tb/scoped_binding_stack_top_tb.sv
// ---------------------------------------------------------------------------
// scoped_binding_stack_top_tb
// Drives add, open, close and find commands into the binding stack with
// random gaps on both channels and random result stalls. Each accepted
// command is run through a local model of the stack, and each result
// transfer is checked against the oldest predicted answer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scoped_binding_stack_top_tb;
  import sbs_pkg::*;

  localparam int DEPTH       = STACK_DEPTH_DEF;
  localparam int QUIET_LIMIT = 8000;
  localparam int SHOW_MAX    = 10;

  typedef struct packed {
    cmd_t               command;
    logic [ATOM_W-1:0]  atom_key;
    logic [FRAME_W-1:0] frame_base;
  } cmd_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   entry_index;
    logic               found;
    logic [FRAME_W-1:0] bound_frame;
    logic [OFS_W-1:0]   local_offset;
    logic [ADDR_W-1:0]  var_address;
    status_t            status;
  } answer_t;

  logic clk;
  logic rst_n;

  sbs_in_if  in_ch ();
  sbs_out_if out_ch ();

  scoped_binding_stack_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Commands waiting to be driven and answers waiting to come back
  cmd_item_t cmd_backlog[$];
  answer_t   answers_due[$];

  // Local copy of the binding stack
  logic [ATOM_W-1:0]  bind_key   [DEPTH];
  bit                 bind_mark  [DEPTH];
  logic [FRAME_W-1:0] bind_frame [DEPTH];
  logic [LCNT_W-1:0]  bind_count [DEPTH];
  int                 sim_top;
  logic [FRAME_W-1:0] sim_frame;
  logic [LCNT_W-1:0]  sim_count;

  // Shadow depth used only to shape the stimulus
  int gen_top;
  int gen_marks[$];
  logic [ATOM_W-1:0] key_pool[8];

  int idle_pct;
  bit cmd_taken;
  int quiet_cycles;
  int fault_count;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit take_break();
    return $urandom_range(99) < idle_pct;
  endfunction

  // Apply one command to the local stack and return its answer
  function automatic answer_t resolve_command(cmd_item_t it);
    answer_t a;
    int k;
    bit done;
    logic [FRAME_W-1:0] f;
    logic [OFS_W-1:0] o;
    a = '0;
    done = 1'b0;
    case (it.command)
      CMD_ADD, CMD_OPEN: begin
        if (sim_top >= DEPTH) begin
          a.status = ST_FULL;
        end else begin
          a.entry_index = sim_top[IDX_W-1:0];
          a.status = ST_OK;
          bind_mark[sim_top] = (it.command == CMD_OPEN);
          bind_key[sim_top] = it.atom_key;
          bind_frame[sim_top] = sim_frame;
          bind_count[sim_top] = sim_count;
          if (it.command == CMD_OPEN) begin
            sim_frame = it.frame_base;
            sim_count = '0;
          end else begin
            a.local_offset = sim_count[OFS_W-1:0];
            sim_count = sim_count + LCNT_W'(1);
          end
          sim_top++;
        end
      end
      CMD_CLOSE: begin
        // Truncate at the newest marker and restore the outer frame
        a.status = ST_NOFRAME;
        k = sim_top - 1;
        while (k >= 0 && !done) begin
          if (bind_mark[k]) begin
            a.entry_index = k[IDX_W-1:0];
            a.status = ST_OK;
            sim_top = k;
            sim_frame = bind_frame[k];
            sim_count = bind_count[k];
            done = 1'b1;
          end
          k--;
        end
      end
      default: begin
        // Newest non-marker entry with a matching key
        a.status = ST_NOTFOUND;
        k = sim_top - 1;
        while (k >= 0 && !done) begin
          if (!bind_mark[k] && bind_key[k] == it.atom_key) begin
            f = bind_frame[k];
            o = bind_count[k][OFS_W-1:0];
            a.entry_index = k[IDX_W-1:0];
            a.found = 1'b1;
            a.bound_frame = f;
            a.local_offset = o;
            a.var_address = ADDR_W'(f) + ADDR_W'(o);
            a.status = ST_OK;
            done = 1'b1;
          end
          k--;
        end
      end
    endcase
    return a;
  endfunction

  // Drive commands; advance only after a transfer or while idle
  always @(negedge clk) begin
    cmd_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || cmd_taken) begin
      if (cmd_backlog.size() != 0 && !take_break()) begin
        nxt = cmd_backlog.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.command    <= nxt.command;
        in_ch.atom_key   <= nxt.atom_key;
        in_ch.frame_base <= nxt.frame_base;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ch.ready <= rst_n && !take_break();
  end

  // Predict on command transfers, check result transfers, watch for a hang
  always @(posedge clk) begin
    cmd_item_t it;
    answer_t want;
    answer_t got;
    bit in_xfer;
    bit out_xfer;
    if (!rst_n) begin
      cmd_taken <= 1'b0;
      quiet_cycles <= 0;
      sim_top = 0;
      sim_frame = '0;
      sim_count = '0;
    end else begin
      in_xfer = in_ch.valid && in_ch.ready;
      out_xfer = out_ch.valid && out_ch.ready;
      cmd_taken <= in_xfer;
      if (in_xfer) begin
        it.command = cmd_t'(in_ch.command);
        it.atom_key = in_ch.atom_key;
        it.frame_base = in_ch.frame_base;
        answers_due.push_back(resolve_command(it));
      end
      if (out_xfer) begin
        got.entry_index = out_ch.entry_index;
        got.found = out_ch.found;
        got.bound_frame = out_ch.bound_frame;
        got.local_offset = out_ch.local_offset;
        got.var_address = out_ch.var_address;
        got.status = status_t'(out_ch.status);
        if (answers_due.size() == 0) begin
          fault_count++;
          if (fault_count <= SHOW_MAX)
            $display("%0t: result with nothing pending: idx=%0d st=%0d",
                     $realtime, got.entry_index, got.status);
        end else begin
          want = answers_due.pop_front();
          if (got !== want) begin
            fault_count++;
            if (fault_count <= SHOW_MAX) begin
              $display("%0t: mismatch", $realtime);
              $display("  exp idx=%0d fnd=%0b frm=%h ofs=%0d adr=%h st=%0d",
                       want.entry_index, want.found, want.bound_frame,
                       want.local_offset, want.var_address, want.status);
              $display("  got idx=%0d fnd=%0b frm=%h ofs=%0d adr=%h st=%0d",
                       got.entry_index, got.found, got.bound_frame,
                       got.local_offset, got.var_address, got.status);
            end
          end
        end
      end
      if (in_xfer || out_xfer) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("scoped_binding_stack_top_tb: done, errors");
        $finish;
      end
    end
  end

  // Queue one command and track the shadow depth
  task automatic queue_command(cmd_t c, logic [ATOM_W-1:0] key,
                               logic [FRAME_W-1:0] fbase);
    cmd_item_t it;
    it.command = c;
    it.atom_key = key;
    it.frame_base = fbase;
    cmd_backlog.push_back(it);
    if ((c == CMD_ADD || c == CMD_OPEN) && gen_top < DEPTH) begin
      if (c == CMD_OPEN) gen_marks.push_back(gen_top);
      gen_top++;
    end else if (c == CMD_CLOSE && gen_marks.size() != 0) begin
      gen_top = gen_marks.pop_back();
    end
  endtask

  // Hold until every queued command has been answered
  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || in_ch.valid || answers_due.size() != 0)
      @(negedge clk);
  endtask

  function automatic logic [ATOM_W-1:0] pick_key();
    if ($urandom_range(99) < 75) return key_pool[$urandom_range(7)];
    return ATOM_W'($urandom_range(16383));
  endfunction

  function automatic logic [FRAME_W-1:0] pick_frame();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return FRAME_W'($urandom_range(65535));
  endfunction

  // Mostly scoped add/find traffic inside frames, kept shallow
  task automatic queue_random_mix(int n);
    int r;
    cmd_t c;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (gen_marks.size() == 0)
        c = (r < 55) ? CMD_OPEN : (r < 65) ? CMD_CLOSE :
            (r < 75 && gen_top < 8) ? CMD_ADD : CMD_FIND;
      else if (gen_top > 48)
        c = (r < 40) ? CMD_CLOSE : (r < 80) ? CMD_FIND : CMD_ADD;
      else
        c = (r < 40) ? CMD_ADD : (r < 52) ? CMD_OPEN : (r < 65) ? CMD_CLOSE : CMD_FIND;
      queue_command(c, pick_key(), pick_frame());
    end
  endtask

  // Fill the stack inside one frame, hit the full case, walk it, unwind
  task automatic queue_fill_to_full();
    logic [ATOM_W-1:0] deep_key;
    logic [ATOM_W-1:0] last_key;
    deep_key = ATOM_W'($urandom_range(16383));
    last_key = deep_key;
    queue_command(CMD_OPEN, pick_key(), '1);
    queue_command(CMD_ADD, deep_key, '0);
    while (gen_top < DEPTH) begin
      last_key = ATOM_W'($urandom_range(16383));
      queue_command(CMD_ADD, last_key, pick_frame());
    end
    queue_command(CMD_ADD, pick_key(), '0);
    queue_command(CMD_OPEN, pick_key(), '1);
    queue_command(CMD_FIND, last_key, '0);
    queue_command(CMD_FIND, deep_key, '0);
    queue_command(CMD_FIND, ATOM_W'($urandom_range(16383)), '0);
    while (gen_marks.size() != 0)
      queue_command(CMD_CLOSE, pick_key(), pick_frame());
    queue_command(CMD_CLOSE, '1, '1);
  endtask

  // Stimulus
  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CMD_ADD;
    in_ch.atom_key = '0;
    in_ch.frame_base = '0;
    out_ch.ready = 1'b0;
    cmd_taken = 1'b0;
    fault_count = 0;
    idle_pct = 35;
    gen_top = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 8; i++) key_pool[i] = ATOM_W'($urandom_range(16383));
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty stack, key extremes, shadowing, markers in find
    queue_command(CMD_CLOSE, '0, '0);
    queue_command(CMD_FIND, '0, '0);
    queue_command(CMD_ADD, '0, '0);
    queue_command(CMD_ADD, '1, '1);
    queue_command(CMD_FIND, '1, '0);
    queue_command(CMD_FIND, '0, '1);
    queue_command(CMD_FIND, 14'h1555, '0);
    queue_command(CMD_OPEN, 14'h2AAA, '1);
    queue_command(CMD_FIND, 14'h2AAA, '0);
    queue_command(CMD_ADD, '1, '0);
    queue_command(CMD_ADD, 14'h2AAA, '0);
    queue_command(CMD_FIND, '1, '0);
    queue_command(CMD_OPEN, '1, '0);
    queue_command(CMD_ADD, '0, '1);
    queue_command(CMD_FIND, '0, '0);
    queue_command(CMD_FIND, 14'h2AAA, '0);
    queue_command(CMD_CLOSE, '0, '0);
    queue_command(CMD_FIND, '0, '0);
    queue_command(CMD_CLOSE, '1, '1);
    queue_command(CMD_FIND, '1, '0);
    queue_command(CMD_CLOSE, '0, '0);
    queue_command(CMD_ADD, 14'h1555, 16'h5555);
    wait_drained();

    queue_random_mix(250);
    wait_drained();

    // No gaps on either side while the stack fills
    idle_pct = 0;
    queue_fill_to_full();
    wait_drained();
    idle_pct = 35;

    queue_random_mix(330);
    wait_drained();
    repeat (40) @(posedge clk);

    if (fault_count == 0 && answers_due.size() == 0) begin
      $display("scoped_binding_stack_top_tb: done, clean");
    end else begin
      $display("scoped_binding_stack_top_tb: done, errors");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/sbs_pkg.sv
hw/rtl/sbs_if.sv
hw/rtl/sbs_ram.sv
hw/rtl/sbs_ctrl.sv
hw/rtl/sbs_dp.sv
hw/rtl/scoped_binding_stack_top.sv
tb/scoped_binding_stack_top_tb.sv
